FILE: design/pfx_pkg.sv
`default_nettype none

package pfx_pkg;

    localparam int WORD_W          = 32;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_XOR   = 8'h5E;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } pfx_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     underflow_seen;
        logic                     overflow_seen;
        logic                     div_zero_seen;
    } pfx_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_POP_B,
        ST_POP_A,
        ST_EXEC,
        ST_WAIT,
        ST_PUSH,
        ST_END,
        ST_RPOP,
        ST_REPORT
    } st_t;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_DIV,
        MD_MOD
    } md_op_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX,
        MD_DONE
    } md_state_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic done;
        logic divz;
    } md_rsp_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) ||
               (c == CH_DIV) || (c == CH_MOD) || (c == CH_XOR);
    endfunction

    function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
    endfunction

endpackage

`default_nettype wire

FILE: design/pfx_muldiv.sv
`default_nettype none

module pfx_muldiv (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pfx_pkg::md_req_t           req,
    input  wire logic [pfx_pkg::WORD_W-1:0] a,
    input  wire logic [pfx_pkg::WORD_W-1:0] b,
    output pfx_pkg::md_rsp_t                rsp,
    output logic [pfx_pkg::WORD_W-1:0]      result
);
    import pfx_pkg::*;

    localparam int CW = $clog2(WORD_W);

    md_state_t          state_reg, state_next;
    md_op_t             op_reg, op_next;
    logic [WORD_W-1:0]  x_reg, x_next;
    logic [WORD_W-1:0]  y_reg, y_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic [WORD_W-1:0]  res_reg, res_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               negq_reg, negq_next;
    logic               negr_reg, negr_next;
    logic               divz_reg, divz_next;

    logic [WORD_W:0]    rem_shift;
    logic [WORD_W+1:0]  trial;
    logic               ge;

    // one restoring-division step: shift in next dividend bit, try subtract
    assign rem_shift = {acc_reg, y_reg[WORD_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, x_reg};
    assign ge        = !trial[WORD_W+1];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op != MD_MUL && b == '0)
                        state_next = MD_FIX;
                    else
                        state_next = MD_RUN;
                end
            end
            MD_RUN:
            begin
                if (cnt_reg == CW'(WORD_W - 1))
                    state_next = MD_FIX;
            end
            MD_FIX:  state_next = MD_DONE;
            MD_DONE: state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_comb
    begin
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        divz_next = divz_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    acc_next  = '0;
                    cnt_next  = '0;
                    negq_next = a[WORD_W-1] ^ b[WORD_W-1];
                    negr_next = a[WORD_W-1];
                    divz_next = (req.op != MD_MUL) && (b == '0);
                    if (req.op == MD_MUL)
                    begin
                        x_next = a;
                        y_next = b;
                    end
                    else
                    begin
                        x_next = mag(b);
                        y_next = mag(a);
                    end
                end
            end
            MD_RUN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (op_reg == MD_MUL)
                begin
                    if (y_reg[0])
                        acc_next = acc_reg + x_reg;
                    x_next = {x_reg[WORD_W-2:0], 1'b0};
                    y_next = {1'b0, y_reg[WORD_W-1:1]};
                end
                else
                begin
                    acc_next = ge ? trial[WORD_W-1:0] : rem_shift[WORD_W-1:0];
                    y_next   = {y_reg[WORD_W-2:0], ge};
                end
            end
            MD_FIX:
            begin
                if (divz_reg)
                    res_next = '0;
                else
                begin
                    case (op_reg)
                        MD_MUL:  res_next = acc_reg;
                        MD_DIV:  res_next = negq_reg ? (WORD_W'(0) - y_reg) : y_reg;
                        MD_MOD:  res_next = negr_reg ? (WORD_W'(0) - acc_reg) : acc_reg;
                        default: res_next = acc_reg;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= MD_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        cnt_reg  <= cnt_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        divz_reg <= divz_next;
    end

    assign rsp.done = (state_reg == MD_DONE);
    assign rsp.divz = divz_reg;
    assign result   = res_reg;

endmodule

`default_nettype wire

FILE: design/postfix_expression_evaluator.sv
// Postfix expression evaluator.
// Input channel (in_valid / in_stall / in_data): one ASCII character a word,
// with is_last marking the end of the expression. Digits build a decimal
// number; + - * / % ^ pop two operands and push the result onto an internal
// operand stack of STACK_DEPTH 32-bit words.
// Output channel (out_valid / out_stall / out_data): one word per expression,
// sent after the last character: top of stack plus sticky underflow,
// overflow and divide-by-zero flags. State is then cleared for the next one.
// Sequencing: a character is taken only while the sequencer is idle.
//   digits and other characters: FLUSH, END
//   + - ^: FLUSH, POP_B, POP_A, EXEC, PUSH, END
//   * / %: as + - ^ plus WAIT after EXEC, held by the shared 32-step shift-add /
//     restoring-divide unit (start, steps, sign fix, handoff; by zero: no steps)
// A last character also passes RPOP and REPORT before the result word is loaded.
// The result sits in an output register; the next expression is accepted
// while it waits. If the receiver still stalls when the next result is
// ready, the sequencer holds until the register frees up.
// Reset (rst_n, async, active low) empties the stack and clears all flags;
// there is no clearing pass.
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire pfx_pkg::pfx_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output pfx_pkg::pfx_out_t     out_data
);
    import pfx_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    st_t                state_reg, state_next;
    logic [7:0]         char_reg;
    logic               last_reg;
    logic [WORD_W-1:0]  acc_reg, acc_next;
    logic               open_reg, open_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               under_reg, under_next;
    logic               over_reg, over_next;
    logic               divz_reg, divz_next;
    logic               hit_reg, hit_next;
    logic [WORD_W-1:0]  opb_reg, opb_next;
    logic [WORD_W-1:0]  res_reg, res_next;
    logic [WORD_W-1:0]  rd_data_reg;
    pfx_out_t           out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]  stack_mem [STACK_DEPTH];

    logic               push_req, pop_req, clear_req, divz_set, out_load;
    logic [WORD_W-1:0]  push_data;
    logic               mem_we, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [CNT_W-1:0]   cnt_dec;
    logic               full, empty, in_take, out_busy;
    logic [WORD_W-1:0]  pop_val;

    md_req_t            md_req;
    md_rsp_t            md_rsp;
    logic [WORD_W-1:0]  md_result;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_busy = out_valid_reg && out_stall;
    assign full     = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    // value of the last pop: all ones when it hit an empty stack
    assign pop_val  = hit_reg ? rd_data_reg : '1;

    pfx_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .a      (pop_val),
        .b      (opb_reg),
        .rsp    (md_rsp),
        .result (md_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (is_oper(char_reg))
                    state_next = ST_POP_B;
                else
                    state_next = ST_END;
            end
            ST_POP_B: state_next = ST_POP_A;
            ST_POP_A: state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (char_reg == CH_PLUS || char_reg == CH_MINUS || char_reg == CH_XOR)
                    state_next = ST_PUSH;
                else
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                    state_next = ST_PUSH;
            end
            ST_PUSH: state_next = ST_END;
            ST_END:
            begin
                if (last_reg)
                    state_next = ST_RPOP;
                else
                    state_next = ST_IDLE;
            end
            ST_RPOP: state_next = ST_REPORT;
            ST_REPORT:
            begin
                if (!out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        push_req  = 1'b0;
        push_data = acc_reg;
        pop_req   = 1'b0;
        clear_req = 1'b0;
        divz_set  = 1'b0;
        out_load  = 1'b0;
        acc_next  = acc_reg;
        open_next = open_reg;
        opb_next  = opb_reg;
        res_next  = res_reg;
        md_req    = '{start: 1'b0, op: MD_MUL};
        case (state_reg)
            ST_FLUSH:
            begin
                if (is_digit(char_reg))
                begin
                    acc_next  = (acc_reg << 3) + (acc_reg << 1) +
                                WORD_W'(char_reg - CH_ZERO);
                    open_next = 1'b1;
                end
                else if (open_reg)
                begin
                    push_req  = 1'b1;
                    acc_next  = '0;
                    open_next = 1'b0;
                end
            end
            ST_POP_B:
            begin
                pop_req = 1'b1;
            end
            ST_POP_A:
            begin
                opb_next = pop_val;
                pop_req  = 1'b1;
            end
            ST_EXEC:
            begin
                case (char_reg)
                    CH_PLUS:  res_next = pop_val + opb_reg;
                    CH_MINUS: res_next = pop_val - opb_reg;
                    CH_XOR:   res_next = pop_val ^ opb_reg;
                    CH_MUL:   md_req   = '{start: 1'b1, op: MD_MUL};
                    CH_DIV:   md_req   = '{start: 1'b1, op: MD_DIV};
                    default:  md_req   = '{start: 1'b1, op: MD_MOD};
                endcase
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    res_next = md_result;
                    divz_set = md_rsp.divz;
                end
            end
            ST_PUSH:
            begin
                push_req  = 1'b1;
                push_data = res_reg;
            end
            ST_END:
            begin
                if (last_reg && open_reg)
                begin
                    push_req  = 1'b1;
                    acc_next  = '0;
                    open_next = 1'b0;
                end
            end
            ST_RPOP:
            begin
                pop_req = 1'b1;
            end
            ST_REPORT:
            begin
                if (!out_busy)
                begin
                    out_load  = 1'b1;
                    clear_req = 1'b1;
                    acc_next  = '0;
                    open_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // stack pointer, memory port control and sticky flags
    always_comb
    begin
        cnt_next   = cnt_reg;
        under_next = under_reg;
        over_next  = over_reg;
        divz_next  = divz_reg || divz_set;
        hit_next   = hit_reg;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        rd_addr    = cnt_dec[AW-1:0];
        if (push_req)
        begin
            if (full)
                over_next = 1'b1;
            else
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        if (pop_req)
        begin
            if (empty)
            begin
                under_next = 1'b1;
                hit_next   = 1'b0;
            end
            else
            begin
                rd_en    = 1'b1;
                hit_next = 1'b1;
                cnt_next = cnt_dec;
            end
        end
        if (clear_req)
        begin
            cnt_next   = '0;
            under_next = 1'b0;
            over_next  = 1'b0;
            divz_next  = 1'b0;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_busy;
        if (out_load)
        begin
            out_next.result_value   = pop_val;
            out_next.underflow_seen = under_reg;
            out_next.overflow_seen  = over_reg;
            out_next.div_zero_seen  = divz_reg;
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            open_reg      <= 1'b0;
            cnt_reg       <= '0;
            under_reg     <= 1'b0;
            over_reg      <= 1'b0;
            divz_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            open_reg      <= open_next;
            cnt_reg       <= cnt_next;
            under_reg     <= under_next;
            over_reg      <= over_next;
            divz_reg      <= divz_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= in_data.char_code;
            last_reg <= in_data.is_last;
        end
        opb_reg <= opb_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[wr_addr] <= push_data;
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_out_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_REPORT))
        else $error("result word raised outside report");

    a_md_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg == ST_WAIT))
        else $error("multiply/divide finished while sequencer not waiting");

    a_clear_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && !out_busy) |=>
            (cnt_reg == '0 && !open_reg && !under_reg && !over_reg && !divz_reg))
        else $error("state not cleared after report");

endmodule

`default_nettype wire
